### sv/sdf_pkg.sv
package sdf_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 31;
  localparam int WIDE_W    = 62;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W      = 5;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [WIDE_W:0]   sum_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CFG_W-1:0]         cfg_t;
  typedef logic [PC_W-1:0]          pc_t;

  localparam wide_t WIDE_MAX   = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam sum_t  SUM_MAX    = {1'b0, WIDE_MAX};
  localparam wide_t DATA_MAX_W = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam wide_t DATA_MIN_W = -DATA_MAX_W - wide_t'(1);

  localparam cfg_t  ST_FLOOR = CFG_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam wide_t K048     = wide_t'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam wide_t K0235    = wide_t'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam wide_t ONE_Q    = wide_t'(64'd1 << FRAC_BITS);
  localparam wide_t TWO_QQ   = wide_t'(64'd2 << (2 * FRAC_BITS));
  localparam wide_t ONE_QQ   = wide_t'(64'd1 << (2 * FRAC_BITS));

  localparam cfg_t ST_RST = CFG_W'(19661);
  localparam cfg_t MS_RST = CFG_W'(2147483647);
  localparam cfg_t DT_RST = CFG_W'(1092);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH_TIME,
    REG_MAX_SPEED,
    REG_DELTA_TIME
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SUB,
    OP_CLAMP,
    OP_FIN,
    OP_END
  } op_kind_t;

  typedef enum logic [4:0] {
    OPN_ST,
    OPN_MAXSPD,
    OPN_DT,
    OPN_K048,
    OPN_K0235,
    OPN_ONE,
    OPN_TWO_QQ,
    OPN_ONE_QQ,
    OPN_CUR,
    OPN_TGT,
    OPN_VEL,
    OPN_OMEGA,
    OPN_DECAY,
    OPN_CLIM,
    OPN_W,
    OPN_W2,
    OPN_W3,
    OPN_DEN,
    OPN_T,
    OPN_CHG,
    OPN_ADJ,
    OPN_TMP,
    OPN_S,
    OPN_NV,
    OPN_RES
  } opnd_t;

  localparam int NUM_OPND = 25;

  typedef struct packed {
    op_kind_t kind;
    opnd_t    a;
    opnd_t    b;
    opnd_t    dst;
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis;
    logic exec;
    logic start;
    logic load_in;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic out_busy;
  } ctrl_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_DONE
  } ctrl_state_t;

  localparam pc_t AXIS_PC = PC_W'(12);

  function automatic op_t prog_op(input pc_t pc);
    op_t op;
    op = '{OP_END, OPN_ONE, OPN_ONE, OPN_T};
    case (pc)
      5'd0:  op = '{OP_DIV,   OPN_TWO_QQ, OPN_ST,    OPN_OMEGA};
      5'd1:  op = '{OP_MUL,   OPN_OMEGA,  OPN_DT,    OPN_W};
      5'd2:  op = '{OP_MUL,   OPN_W,      OPN_W,     OPN_W2};
      5'd3:  op = '{OP_MUL,   OPN_W2,     OPN_W,     OPN_W3};
      5'd4:  op = '{OP_ADD,   OPN_ONE,    OPN_W,     OPN_DEN};
      5'd5:  op = '{OP_MUL,   OPN_K048,   OPN_W2,    OPN_T};
      5'd6:  op = '{OP_ADD,   OPN_DEN,    OPN_T,     OPN_DEN};
      5'd7:  op = '{OP_MUL,   OPN_K0235,  OPN_W3,    OPN_T};
      5'd8:  op = '{OP_ADD,   OPN_DEN,    OPN_T,     OPN_DEN};
      5'd9:  op = '{OP_DIV,   OPN_ONE_QQ, OPN_DEN,   OPN_DECAY};
      5'd10: op = '{OP_MUL,   OPN_MAXSPD, OPN_ST,    OPN_CLIM};
      5'd11: op = '{OP_END,   OPN_ONE,    OPN_ONE,   OPN_T};
      5'd12: op = '{OP_CLAMP, OPN_CUR,    OPN_TGT,   OPN_CHG};
      5'd13: op = '{OP_SUB,   OPN_CUR,    OPN_CHG,   OPN_ADJ};
      5'd14: op = '{OP_MUL,   OPN_OMEGA,  OPN_CHG,   OPN_T};
      5'd15: op = '{OP_ADD,   OPN_VEL,    OPN_T,     OPN_S};
      5'd16: op = '{OP_MUL,   OPN_S,      OPN_DT,    OPN_TMP};
      5'd17: op = '{OP_MUL,   OPN_OMEGA,  OPN_TMP,   OPN_T};
      5'd18: op = '{OP_SUB,   OPN_VEL,    OPN_T,     OPN_S};
      5'd19: op = '{OP_MUL,   OPN_S,      OPN_DECAY, OPN_NV};
      5'd20: op = '{OP_ADD,   OPN_CHG,    OPN_TMP,   OPN_S};
      5'd21: op = '{OP_MUL,   OPN_S,      OPN_DECAY, OPN_T};
      5'd22: op = '{OP_ADD,   OPN_ADJ,    OPN_T,     OPN_RES};
      5'd23: op = '{OP_FIN,   OPN_CUR,    OPN_TGT,   OPN_RES};
      default: op = '{OP_END, OPN_ONE, OPN_ONE, OPN_T};
    endcase
    return op;
  endfunction

  function automatic wide_t satw(input sum_t v);
    wide_t r;
    if (v > SUM_MAX) begin
      r = WIDE_MAX;
    end else if (v < -SUM_MAX) begin
      r = -WIDE_MAX;
    end else begin
      r = v[WIDE_W-1:0];
    end
    return r;
  endfunction

  function automatic data_t satd(input wide_t v);
    data_t r;
    if (v > DATA_MAX_W) begin
      r = DATA_MAX_W[DATA_W-1:0];
    end else if (v < DATA_MIN_W) begin
      r = DATA_MIN_W[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/sdf_in_if.sv
interface sdf_in_if;
  logic                 valid;
  logic                 ready;
  sdf_pkg::data_t       current_x;
  sdf_pkg::data_t       current_y;
  sdf_pkg::data_t       target_x;
  sdf_pkg::data_t       target_y;

  modport source (output valid, output current_x, output current_y,
                  output target_x, output target_y, input ready);
  modport sink   (input valid, input current_x, input current_y,
                  input target_x, input target_y, output ready);
endinterface

### sv/sdf_out_if.sv
interface sdf_out_if;
  logic                 valid;
  logic                 ready;
  sdf_pkg::data_t       next_x;
  sdf_pkg::data_t       next_y;
  sdf_pkg::data_t       speed_x;
  sdf_pkg::data_t       speed_y;

  modport source (output valid, output next_x, output next_y,
                  output speed_x, output speed_y, input ready);
  modport sink   (input valid, input next_x, input next_y,
                  input speed_x, input speed_y, output ready);
endinterface

### sv/sdf_mul.sv
module sdf_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  sdf_pkg::wide_t a,
  input  sdf_pkg::wide_t b,
  output logic           done,
  output sdf_pkg::wide_t result
);

  localparam int MAG_W  = sdf_pkg::WIDE_W - 1;
  localparam int HALF_W = 32;
  localparam int ACC_W  = 2 * MAG_W;
  localparam logic [2:0] LAST_STEP = 3'd4;

  logic             busy_r;
  logic             done_r;
  logic [2:0]       cnt_r;
  logic             neg_r;
  logic [MAG_W-1:0] ua_r;
  logic [MAG_W-1:0] ub_r;
  logic [2*HALF_W-1:0] prod_r;
  logic [1:0]       part_r;
  logic [ACC_W-1:0] acc_r;

  logic [HALF_W-1:0]   a_sel;
  logic [HALF_W-1:0]   b_sel;
  logic [2*HALF_W-1:0] prod_nxt;
  logic [ACC_W-1:0]    addend;
  logic [ACC_W:0]      rnd;
  logic [ACC_W:0]      mag_full;
  sdf_pkg::wide_t      mag;

  always_comb begin
    a_sel    = cnt_r[1] ? HALF_W'(ua_r[MAG_W-1:HALF_W]) : ua_r[HALF_W-1:0];
    b_sel    = cnt_r[0] ? HALF_W'(ub_r[MAG_W-1:HALF_W]) : ub_r[HALF_W-1:0];
    prod_nxt = (2*HALF_W)'(a_sel) * (2*HALF_W)'(b_sel);
    case (part_r)
      2'd0:    addend = ACC_W'(prod_r);
      2'd3:    addend = ACC_W'(prod_r) << (2 * HALF_W);
      default: addend = ACC_W'(prod_r) << HALF_W;
    endcase
    rnd      = {1'b0, acc_r} + (ACC_W+1)'(1 << (sdf_pkg::FRAC_BITS - 1));
    mag_full = rnd >> sdf_pkg::FRAC_BITS;
    if (mag_full > (ACC_W+1)'(sdf_pkg::WIDE_MAX)) begin
      mag = sdf_pkg::WIDE_MAX;
    end else begin
      mag = mag_full[sdf_pkg::WIDE_W-1:0];
    end
    result = neg_r ? -mag : mag;
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[sdf_pkg::WIDE_W-1] != b[sdf_pkg::WIDE_W-1];
      ua_r  <= a[sdf_pkg::WIDE_W-1] ? MAG_W'(-a) : MAG_W'(a);
      ub_r  <= b[sdf_pkg::WIDE_W-1] ? MAG_W'(-b) : MAG_W'(b);
      acc_r <= '0;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
      part_r <= cnt_r[1:0];
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + addend;
      end
    end
  end

endmodule

### sv/sdf_div.sv
module sdf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sdf_pkg::WIDE_W-1:0]   num,
  input  logic [sdf_pkg::WIDE_W-1:0]   den,
  output logic                         done,
  output sdf_pkg::wide_t               quo
);

  localparam int W = sdf_pkg::WIDE_W;
  localparam logic [5:0] LAST_BIT = 6'(W - 1);

  logic         busy_r;
  logic         done_r;
  logic [5:0]   cnt_r;
  logic [W-1:0] num_r;
  logic [W-1:0] den_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] q_r;

  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? W'(trial - {1'b0, den_r}) : W'(trial);
  end

  assign done = done_r;
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_BIT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[W-2:0], ge};
    end
  end

endmodule

### sv/sdf_ctrl.sv
module sdf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdf_pkg::ctrl_sts_t  sts,
  output sdf_pkg::ctrl_cmd_t  cmd
);

  sdf_pkg::ctrl_state_t state_r, state_nxt;
  sdf_pkg::pc_t         pc_r, pc_nxt;
  logic                 axis_r, axis_nxt;
  logic                 pend_r, pend_nxt;
  sdf_pkg::op_t         op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdf_pkg::ST_IDLE;
      pc_r    <= '0;
      axis_r  <= 1'b0;
      pend_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      axis_r  <= axis_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    op           = sdf_pkg::prog_op(pc_r);
    in_ready     = (state_r == sdf_pkg::ST_IDLE) && !pend_r && !cfg_we;
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    axis_nxt     = axis_r;
    pend_nxt     = pend_r;
    cmd          = '0;
    cmd.op       = op;
    cmd.axis     = axis_r;
    unique case (state_r)
      sdf_pkg::ST_IDLE: begin
        if (pend_r) begin
          pend_nxt  = 1'b0;
          pc_nxt    = '0;
          state_nxt = sdf_pkg::ST_RUN;
        end else if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          pc_nxt      = sdf_pkg::AXIS_PC;
          axis_nxt    = 1'b0;
          state_nxt   = sdf_pkg::ST_RUN;
        end
      end
      sdf_pkg::ST_RUN: begin
        unique case (op.kind) inside
          sdf_pkg::OP_MUL, sdf_pkg::OP_DIV: begin
            cmd.start = 1'b1;
            state_nxt = sdf_pkg::ST_WAIT;
          end
          sdf_pkg::OP_ADD, sdf_pkg::OP_SUB, sdf_pkg::OP_CLAMP: begin
            cmd.exec = 1'b1;
            pc_nxt   = pc_r + sdf_pkg::PC_W'(1);
          end
          sdf_pkg::OP_FIN: begin
            cmd.exec = 1'b1;
            if (!axis_r) begin
              axis_nxt = 1'b1;
              pc_nxt   = sdf_pkg::AXIS_PC;
            end else begin
              state_nxt = sdf_pkg::ST_DONE;
            end
          end
          default: begin
            state_nxt = sdf_pkg::ST_IDLE;
          end
        endcase
      end
      sdf_pkg::ST_WAIT: begin
        if (sts.unit_done) begin
          pc_nxt    = pc_r + sdf_pkg::PC_W'(1);
          state_nxt = sdf_pkg::ST_RUN;
        end
      end
      sdf_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = sdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sdf_pkg::ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      pend_nxt = 1'b1;
    end
  end

endmodule

### sv/sdf_dp.sv
module sdf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sdf_pkg::ctrl_cmd_t                  cmd,
  output sdf_pkg::ctrl_sts_t                  sts,
  input  logic                                cfg_we,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  sdf_pkg::cfg_t                       cfg_data,
  input  sdf_pkg::data_t                      in_current_x,
  input  sdf_pkg::data_t                      in_current_y,
  input  sdf_pkg::data_t                      in_target_x,
  input  sdf_pkg::data_t                      in_target_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sdf_pkg::data_t                      out_next_x,
  output sdf_pkg::data_t                      out_next_y,
  output sdf_pkg::data_t                      out_speed_x,
  output sdf_pkg::data_t                      out_speed_y
);

  localparam int W = sdf_pkg::WIDE_W;

  sdf_pkg::cfg_t  st_r, ms_r, dt_r;
  sdf_pkg::wide_t vx_r, vy_r;
  sdf_pkg::data_t cx_r, cy_r, tx_r, ty_r;
  sdf_pkg::wide_t omega_r, decay_r, clim_r, w_r, w2_r, w3_r, den_r;
  sdf_pkg::wide_t t_r, chg_r, adj_r, tmp_r, s_r, nv_r, res_r;
  sdf_pkg::data_t rx_r, ry_r;
  logic           out_valid_r;
  sdf_pkg::data_t onx_r, ony_r, osx_r, osy_r;

  sdf_pkg::cfg_t  st_eff;
  sdf_pkg::wide_t cur, tgt, vel;
  sdf_pkg::wide_t opnd_v [sdf_pkg::NUM_OPND];
  sdf_pkg::wide_t opa, opb;
  sdf_pkg::wide_t chg_raw, alu_res, wr_val;
  logic           wr_en;
  logic           snap;
  sdf_pkg::data_t vel_new, pos_new;
  logic           mul_start, div_start, mul_done, div_done;
  sdf_pkg::wide_t mul_res, div_res;
  logic [W-1:0]   div_num;

  always_comb begin
    st_eff = (st_r < sdf_pkg::ST_FLOOR) ? sdf_pkg::ST_FLOOR : st_r;
    cur    = sdf_pkg::wide_t'(cmd.axis ? cy_r : cx_r);
    tgt    = sdf_pkg::wide_t'(cmd.axis ? ty_r : tx_r);
    vel    = cmd.axis ? vy_r : vx_r;

    opnd_v[sdf_pkg::OPN_ST]     = W'(st_eff);
    opnd_v[sdf_pkg::OPN_MAXSPD] = W'(ms_r);
    opnd_v[sdf_pkg::OPN_DT]     = W'(dt_r);
    opnd_v[sdf_pkg::OPN_K048]   = sdf_pkg::K048;
    opnd_v[sdf_pkg::OPN_K0235]  = sdf_pkg::K0235;
    opnd_v[sdf_pkg::OPN_ONE]    = sdf_pkg::ONE_Q;
    opnd_v[sdf_pkg::OPN_TWO_QQ] = sdf_pkg::TWO_QQ;
    opnd_v[sdf_pkg::OPN_ONE_QQ] = sdf_pkg::ONE_QQ;
    opnd_v[sdf_pkg::OPN_CUR]    = cur;
    opnd_v[sdf_pkg::OPN_TGT]    = tgt;
    opnd_v[sdf_pkg::OPN_VEL]    = vel;
    opnd_v[sdf_pkg::OPN_OMEGA]  = omega_r;
    opnd_v[sdf_pkg::OPN_DECAY]  = decay_r;
    opnd_v[sdf_pkg::OPN_CLIM]   = clim_r;
    opnd_v[sdf_pkg::OPN_W]      = w_r;
    opnd_v[sdf_pkg::OPN_W2]     = w2_r;
    opnd_v[sdf_pkg::OPN_W3]     = w3_r;
    opnd_v[sdf_pkg::OPN_DEN]    = den_r;
    opnd_v[sdf_pkg::OPN_T]      = t_r;
    opnd_v[sdf_pkg::OPN_CHG]    = chg_r;
    opnd_v[sdf_pkg::OPN_ADJ]    = adj_r;
    opnd_v[sdf_pkg::OPN_TMP]    = tmp_r;
    opnd_v[sdf_pkg::OPN_S]      = s_r;
    opnd_v[sdf_pkg::OPN_NV]     = nv_r;
    opnd_v[sdf_pkg::OPN_RES]    = res_r;

    opa = opnd_v[cmd.op.a];
    opb = opnd_v[cmd.op.b];

    chg_raw = opa - opb;
    case (cmd.op.kind)
      sdf_pkg::OP_SUB: alu_res = sdf_pkg::satw(sdf_pkg::sum_t'(opa) - sdf_pkg::sum_t'(opb));
      sdf_pkg::OP_CLAMP: begin
        if (chg_raw > clim_r) begin
          alu_res = clim_r;
        end else if (chg_raw < -clim_r) begin
          alu_res = -clim_r;
        end else begin
          alu_res = chg_raw;
        end
      end
      default: alu_res = sdf_pkg::satw(sdf_pkg::sum_t'(opa) + sdf_pkg::sum_t'(opb));
    endcase

    snap    = ((tgt - cur) > sdf_pkg::wide_t'(0)) == (res_r > tgt);
    vel_new = snap ? '0 : sdf_pkg::satd(nv_r);
    pos_new = snap ? tgt[sdf_pkg::DATA_W-1:0] : sdf_pkg::satd(res_r);

    mul_start = cmd.start && (cmd.op.kind == sdf_pkg::OP_MUL);
    div_start = cmd.start && (cmd.op.kind == sdf_pkg::OP_DIV);
    div_num   = W'(opa) + (W'(opb) >> 1);

    wr_en  = 1'b0;
    wr_val = alu_res;
    if (mul_done) begin
      wr_en  = 1'b1;
      wr_val = mul_res;
    end else if (div_done) begin
      wr_en  = 1'b1;
      wr_val = div_res;
    end else if (cmd.exec && (cmd.op.kind != sdf_pkg::OP_FIN)) begin
      wr_en = 1'b1;
    end

    sts.unit_done = mul_done || div_done;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  sdf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (opa),
    .b      (opb),
    .done   (mul_done),
    .result (mul_res)
  );

  sdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (W'(opb)),
    .done  (div_done),
    .quo   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= sdf_pkg::ST_RST;
      ms_r        <= sdf_pkg::MS_RST;
      dt_r        <= sdf_pkg::DT_RST;
      vx_r        <= '0;
      vy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sdf_pkg::REG_SMOOTH_TIME: st_r <= cfg_data;
          sdf_pkg::REG_MAX_SPEED:   ms_r <= cfg_data;
          sdf_pkg::REG_DELTA_TIME:  dt_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec && (cmd.op.kind == sdf_pkg::OP_FIN)) begin
        if (cmd.axis) begin
          vy_r <= sdf_pkg::wide_t'(vel_new);
        end else begin
          vx_r <= sdf_pkg::wide_t'(vel_new);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cx_r <= in_current_x;
      cy_r <= in_current_y;
      tx_r <= in_target_x;
      ty_r <= in_target_y;
    end
    if (cmd.exec && (cmd.op.kind == sdf_pkg::OP_FIN)) begin
      if (cmd.axis) begin
        ry_r <= pos_new;
      end else begin
        rx_r <= pos_new;
      end
    end
    if (cmd.load_out) begin
      onx_r <= rx_r;
      ony_r <= ry_r;
      osx_r <= sdf_pkg::satd(vx_r);
      osy_r <= sdf_pkg::satd(vy_r);
    end
    if (wr_en) begin
      case (cmd.op.dst)
        sdf_pkg::OPN_OMEGA: omega_r <= wr_val;
        sdf_pkg::OPN_DECAY: decay_r <= wr_val;
        sdf_pkg::OPN_CLIM:  clim_r  <= wr_val;
        sdf_pkg::OPN_W:     w_r     <= wr_val;
        sdf_pkg::OPN_W2:    w2_r    <= wr_val;
        sdf_pkg::OPN_W3:    w3_r    <= wr_val;
        sdf_pkg::OPN_DEN:   den_r   <= wr_val;
        sdf_pkg::OPN_T:     t_r     <= wr_val;
        sdf_pkg::OPN_CHG:   chg_r   <= wr_val;
        sdf_pkg::OPN_ADJ:   adj_r   <= wr_val;
        sdf_pkg::OPN_TMP:   tmp_r   <= wr_val;
        sdf_pkg::OPN_S:     s_r     <= wr_val;
        sdf_pkg::OPN_NV:    nv_r    <= wr_val;
        sdf_pkg::OPN_RES:   res_r   <= wr_val;
        default: ;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_next_x  = onx_r;
  assign out_next_y  = ony_r;
  assign out_speed_x = osx_r;
  assign out_speed_y = osy_r;

endmodule

### sv/smooth_damp_follower_2d.sv
// Two-axis critically damped follower in signed Q16.16. Each transfer on the
// input channel brings a position and a target per axis and produces one
// transfer on the output channel with the new position and velocity per axis.
// One shared 32x32 multiplier, used four times per wide product, and a
// one-bit-per-cycle divider carry all products and quotients under a small
// sequencer; adds, subtracts and the clamp run in the datapath. Each item
// needs ten wide products through the shared multiplier; the next item is
// taken while a result still waits on the output. After reset and after every
// configuration write the coefficients are recomputed, a pass dominated by
// the two divisions, and no item is taken during that time.
module smooth_damp_follower_2d (
  input  logic                           clk,
  input  logic                           rst_n,
  sdf_in_if.sink                         in_ch,
  sdf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  sdf_pkg::cfg_t                  cfg_data
);

  sdf_pkg::ctrl_cmd_t cmd;
  sdf_pkg::ctrl_sts_t sts;
  logic               in_ready;

  sdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_current_x (in_ch.current_x),
    .in_current_y (in_ch.current_y),
    .in_target_x  (in_ch.target_x),
    .in_target_y  (in_ch.target_y),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_next_x   (out_ch.next_x),
    .out_next_y   (out_ch.next_y),
    .out_speed_x  (out_ch.speed_x),
    .out_speed_y  (out_ch.speed_y)
  );

  assign in_ch.ready = in_ready;

endmodule

### sv/sdf_checker.sv
module sdf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input sdf_pkg::data_t out_next_x,
  input sdf_pkg::data_t out_speed_x,
  input logic           cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_next_x) && $stable(out_speed_x))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input ready before coefficients were recomputed");

endmodule

bind smooth_damp_follower_2d sdf_checker u_sdf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_next_x  (out_ch.next_x),
  .out_speed_x (out_ch.speed_x),
  .cfg_we      (cfg_we)
);

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  SETTLE_WAIT  = 250;
  localparam int  RANDOM_ITEMS = 1060;
  localparam longint WMAX      = (64'sd1 <<< 61) - 1;
  localparam longint DMAX      = 64'sd2147483647;
  localparam longint DMIN      = -64'sd2147483648;
  localparam logic [sdf_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam longint STFLOOR   = 7;

  typedef struct {
    sdf_pkg::data_t nx;
    sdf_pkg::data_t ny;
    sdf_pkg::data_t vx;
    sdf_pkg::data_t vy;
  } motion_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index;
  sdf_pkg::cfg_t cfg_data;

  sdf_in_if  in_ch ();
  sdf_out_if out_ch ();

  smooth_damp_follower_2d i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  motion_t motion_q[$];
  int      errors;
  int      cycles;
  int      hold_request;
  bit      calm;
  bit      offering;

  longint smooth_t, max_spd, step_dt;
  longint vel_x, vel_y;
  longint omega, decay, clim;
  longint pos_x, pos_y;

  function automatic longint sat_wide(input longint v);
    if (v > WMAX) return WMAX;
    if (v < -WMAX) return -WMAX;
    return v;
  endfunction

  function automatic longint sat_data(input longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    bit [127:0] p;
    bit [63:0]  ua, ub;
    bit         neg;
    longint     r;
    a = sat_wide(a);
    b = sat_wide(b);
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + 128'd32768) >> sdf_pkg::FRAC_BITS;
    if (p > 128'(WMAX)) r = WMAX;
    else r = longint'(p[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic void derive_coefs();
    bit [63:0] st, den;
    longint w, w2, w3, d;
    st = (smooth_t < STFLOOR) ? STFLOOR : smooth_t;
    omega = longint'(((64'd2 << 32) + st / 2) / st);
    w  = fx_mul(omega, step_dt);
    w2 = fx_mul(w, w);
    w3 = fx_mul(w2, w);
    d = sat_wide(longint'(sdf_pkg::ONE_Q) + w);
    d = sat_wide(d + fx_mul(longint'(sdf_pkg::K048), w2));
    d = sat_wide(d + fx_mul(longint'(sdf_pkg::K0235), w3));
    den = d;
    decay = longint'(((64'd1 << 32) + den / 2) / den);
    clim = fx_mul(max_spd, longint'(st));
  endfunction

  function automatic longint damp_axis(input longint cur, input longint tgt,
                                       inout longint vel);
    longint chg, adj, tmp, nv, res;
    chg = cur - tgt;
    if (chg > clim) chg = clim;
    if (chg < -clim) chg = -clim;
    adj = cur - chg;
    tmp = fx_mul(sat_wide(vel + fx_mul(omega, chg)), step_dt);
    nv  = fx_mul(sat_wide(vel - fx_mul(omega, tmp)), decay);
    res = sat_wide(adj + fx_mul(sat_wide(chg + tmp), decay));
    if ((tgt - cur > 0) == (res > tgt)) begin
      res = tgt;
      nv = 0;
    end
    vel = sat_data(nv);
    return sat_data(res);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Result side: checks each transfer, stalls ready randomly or on request.
  initial begin : result_side
    int stall;
    motion_t e;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (motion_q.size() == 0) begin
          $display("%0t unexpected result transfer", $time);
          errors++;
        end else begin
          e = motion_q.pop_front();
          if (out_ch.next_x !== e.nx) begin
            $display("%0t next_x expected %h actual %h", $time, e.nx, out_ch.next_x);
            errors++;
          end
          if (out_ch.next_y !== e.ny) begin
            $display("%0t next_y expected %h actual %h", $time, e.ny, out_ch.next_y);
            errors++;
          end
          if (out_ch.speed_x !== e.vx) begin
            $display("%0t speed_x expected %h actual %h", $time, e.vx, out_ch.speed_x);
            errors++;
          end
          if (out_ch.speed_y !== e.vy) begin
            $display("%0t speed_y expected %h actual %h", $time, e.vy, out_ch.speed_y);
            errors++;
          end
        end
      end
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      end
    end
  end

  task automatic send_motion(input sdf_pkg::data_t cx, input sdf_pkg::data_t cy,
                             input sdf_pkg::data_t tx, input sdf_pkg::data_t ty);
    int gap;
    motion_t e;
    longint nx, ny;
    gap = 0;
    if (!calm) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (offering && gap > 0) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.current_x <= cx;
    in_ch.current_y <= cy;
    in_ch.target_x  <= tx;
    in_ch.target_y  <= ty;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    nx = damp_axis(longint'(cx), longint'(tx), vel_x);
    ny = damp_axis(longint'(cy), longint'(ty), vel_y);
    e.nx = sdf_pkg::data_t'(nx);
    e.ny = sdf_pkg::data_t'(ny);
    e.vx = sdf_pkg::data_t'(vel_x);
    e.vy = sdf_pkg::data_t'(vel_y);
    pos_x = nx;
    pos_y = ny;
    motion_q.push_back(e);
  endtask

  task automatic stop_offering();
    if (offering) in_ch.valid <= 1'b0;
    offering = 1'b0;
  endtask

  task automatic wait_drained();
    stop_offering();
    @(posedge clk);
    while (motion_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sdf_pkg::CFG_IDX_W-1:0] idx,
                           input sdf_pkg::cfg_t value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdf_pkg::REG_SMOOTH_TIME: smooth_t = value;
      sdf_pkg::REG_MAX_SPEED:   max_spd  = value;
      sdf_pkg::REG_DELTA_TIME:  step_dt  = value;
      default: ;
    endcase
    if (idx != REG_NONE) derive_coefs();
  endtask

  task automatic test_directed();
    send_motion(32'sh0001_0000, -32'sh0001_0000, 32'sh0005_0000, -32'sh0005_0000);
    send_motion(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    send_motion(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    send_motion(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    send_motion(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_motion(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_motion(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001);
    send_motion(32'sh0003_0000, -32'sh0003_0000, 32'sh0000_0000, 32'sh0000_0000);
    send_motion(-32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, -32'sh0000_8000);
  endtask

  task automatic test_register_extremes();
    write_reg(sdf_pkg::REG_SMOOTH_TIME, '0);
    send_motion(32'sh0000_0000, 32'sh0010_0000, 32'sh0100_0000, -32'sh0100_0000);
    send_motion(32'sh7fff_ffff, 32'sh0000_0000, 32'sh8000_0000, 32'sh0000_0001);
    write_reg(sdf_pkg::REG_SMOOTH_TIME, 31'h7fff_ffff);
    write_reg(sdf_pkg::REG_MAX_SPEED, '0);
    send_motion(32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, -32'sh0002_0000);
    write_reg(sdf_pkg::REG_MAX_SPEED, 31'h0001_0000);
    write_reg(sdf_pkg::REG_SMOOTH_TIME, 31'h0000_8000);
    send_motion(32'sh0000_0000, 32'sh0000_0000, 32'sh0100_0000, -32'sh0100_0000);
    send_motion(32'sh0000_4000, -32'sh0000_4000, 32'sh0100_0000, -32'sh0100_0000);
    write_reg(sdf_pkg::REG_DELTA_TIME, 31'h7fff_ffff);
    send_motion(32'sh0000_0000, 32'sh0000_0000, 32'sh0010_0000, -32'sh0010_0000);
    write_reg(sdf_pkg::REG_DELTA_TIME, 31'd1);
    send_motion(32'sh0000_0000, 32'sh0000_0000, 32'sh0010_0000, -32'sh0010_0000);
    write_reg(REG_NONE, 31'h7fff_ffff);
    send_motion(32'sh0000_0000, 32'sh0000_0000, 32'sh0010_0000, -32'sh0010_0000);
    write_reg(sdf_pkg::REG_MAX_SPEED, 31'h7fff_ffff);
    write_reg(sdf_pkg::REG_SMOOTH_TIME, sdf_pkg::ST_RST);
    write_reg(sdf_pkg::REG_DELTA_TIME, sdf_pkg::DT_RST);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_request = 400;
    for (int i = 0; i < 12; i++)
      send_motion(sdf_pkg::data_t'($urandom_range(0, 65535) <<< 4),
                  sdf_pkg::data_t'(i <<< 16), 32'sh0040_0000, -32'sh0040_0000);
    wait_drained();
    send_motion(32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000);
  endtask

  task automatic random_phase(input int count);
    sdf_pkg::data_t cx, cy, tx, ty;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        cx = sdf_pkg::data_t'(pos_x);
        cy = sdf_pkg::data_t'(pos_y);
        if ($urandom_range(0, 19) == 0) begin
          tx = sdf_pkg::data_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
          ty = sdf_pkg::data_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        end else begin
          tx = in_ch.target_x;
          ty = in_ch.target_y;
        end
      end else if (mode < 85) begin
        cx = sdf_pkg::data_t'($urandom());
        cy = sdf_pkg::data_t'($urandom());
        tx = sdf_pkg::data_t'($urandom());
        ty = sdf_pkg::data_t'($urandom());
      end else begin
        cx = sdf_pkg::data_t'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        cy = sdf_pkg::data_t'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        tx = ($urandom_range(0, 3) == 0) ? cx :
             sdf_pkg::data_t'($urandom_range(0, 32'h000f_ffff));
        ty = ($urandom_range(0, 3) == 0) ? cy :
             -sdf_pkg::data_t'($urandom_range(0, 32'h000f_ffff));
      end
      send_motion(cx, cy, tx, ty);
    end
  endtask

  task automatic test_random_settings();
    random_phase(RANDOM_ITEMS / 4);
    write_reg(sdf_pkg::REG_SMOOTH_TIME, sdf_pkg::cfg_t'($urandom_range(2000, 200000)));
    write_reg(sdf_pkg::REG_DELTA_TIME, sdf_pkg::cfg_t'($urandom_range(100, 8000)));
    random_phase(RANDOM_ITEMS / 4);
    write_reg(sdf_pkg::REG_MAX_SPEED, sdf_pkg::cfg_t'($urandom_range(1 << 16, 1 << 24)));
    random_phase(RANDOM_ITEMS / 4);
    write_reg(sdf_pkg::REG_SMOOTH_TIME, sdf_pkg::cfg_t'($urandom()));
    write_reg(sdf_pkg::REG_MAX_SPEED, sdf_pkg::cfg_t'($urandom()));
    write_reg(sdf_pkg::REG_DELTA_TIME,
              sdf_pkg::cfg_t'($urandom_range(1, 32'h7fff_ffff)));
    random_phase(RANDOM_ITEMS / 4);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_request = 0;
    calm = 1'b0;
    offering = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sdf_pkg::REG_SMOOTH_TIME;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.current_x = '0;
    in_ch.current_y = '0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    smooth_t = sdf_pkg::ST_RST;
    max_spd = sdf_pkg::MS_RST;
    step_dt = sdf_pkg::DT_RST;
    vel_x = 0;
    vel_y = 0;
    pos_x = 0;
    pos_y = 0;
    derive_coefs();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_settings();
    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### smooth_damp_follower_2d.f
sv/sdf_pkg.sv
sv/sdf_in_if.sv
sv/sdf_out_if.sv
sv/sdf_mul.sv
sv/sdf_div.sv
sv/sdf_ctrl.sv
sv/sdf_dp.sv
sv/smooth_damp_follower_2d.sv
sv/sdf_checker.sv
test/tb_top.sv
